@@ design/jpeg_header_sof_parser_defines.svh @@
// Assertion macros used by the parser's top-level RTL file.
`ifndef JPEG_HEADER_SOF_PARSER_DEFINES_SVH
`define JPEG_HEADER_SOF_PARSER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define JHSP_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define JHSP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/jhsp_pkg.sv @@
`default_nettype none

package jhsp_pkg;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_SOI    = 3'd1;
    localparam logic [2:0] ST_NO_FF     = 3'd2;
    localparam logic [2:0] ST_BAD_SOF   = 3'd3;
    localparam logic [2:0] ST_BAD_COUNT = 3'd4;

    localparam logic [1:0] FMT_GRAY = 2'd0;
    localparam logic [1:0] FMT_NV16 = 2'd1;
    localparam logic [1:0] FMT_NV12 = 2'd2;
    localparam logic [1:0] FMT_NONE = 2'd3;

    typedef struct packed {
        logic        emit;
        logic [2:0]  status;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [1:0]  pixel_format;
        logic [15:0] header_length;
    } result_t;

endpackage

`default_nettype wire

@@ design/jpeg_header_sof_parser.sv @@
// JPEG header parser for baseline SOF0 streams.
// The input channel (in_valid, in_ready) carries one header byte per word in
// data_byte; start_flag marks the first byte of a header and restarts the parser.
// The output channel (out_valid, out_ready) carries one result word: status,
// image_width, image_height, pixel_format and header_length.
// A result appears when the SOS length is known or at once on the byte that
// reveals an error; most bytes give no result.
// A byte accepted into the input register is parsed into the output register,
// and out_valid rises once the output register is loaded.
// The parser takes one byte per cycle while the receiver does not stall; the
// parse step lies between the input register and the output register.
// When the receiver stalls, the held result blocks the parse step, one more
// byte is taken into the input register if it was empty, and then in_ready falls.
// Reset empties both registers and leaves the parser idle; bytes without
// start_flag are then ignored until a start byte arrives.
`default_nettype none

`include "jpeg_header_sof_parser_defines.svh"

module jpeg_header_sof_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        start_flag,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [15:0]      image_width,
    output logic [15:0]      image_height,
    output logic [1:0]       pixel_format,
    output logic [15:0]      header_length
);
    import jhsp_pkg::*;

    logic        s1_valid_reg;
    logic [7:0]  s1_data_reg;
    logic        s1_start_reg;
    logic        s1_advance;
    result_t     step_result;

    logic        out_valid_reg;
    logic [2:0]  status_reg;
    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic [1:0]  format_reg;
    logic [15:0] hdr_len_reg;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    jhsp_parse_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (s1_advance),
        .data_byte  (s1_data_reg),
        .start_flag (s1_start_reg),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg  <= data_byte;
            s1_start_reg <= start_flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_result.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_result.emit)
        begin
            status_reg  <= step_result.status;
            width_reg   <= step_result.image_width;
            height_reg  <= step_result.image_height;
            format_reg  <= step_result.pixel_format;
            hdr_len_reg <= step_result.header_length;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign image_width   = width_reg;
    assign image_height  = height_reg;
    assign pixel_format  = format_reg;
    assign header_length = hdr_len_reg;

    `JHSP_ASSERT_NOW(a_ready_when_free, clk, rst_n, (!out_valid_reg || out_ready), in_ready, "input stalled while output is free")
    `JHSP_ASSERT_NEXT(a_emit_loads_out, clk, rst_n, step_result.emit, out_valid, "parsed result did not reach the output")
    `JHSP_ASSERT_NOW(a_error_fields, clk, rst_n, (out_valid && status != ST_OK), (image_width == 16'd0 && header_length == 16'd0 && pixel_format == FMT_NONE), "error word carries nonzero fields")

endmodule

`default_nettype wire

@@ design/jhsp_parse_core.sv @@
`default_nettype none

module jhsp_parse_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step_en,
    input  wire logic [7:0]        data_byte,
    input  wire logic              start_flag,
    output jhsp_pkg::result_t      result
);
    import jhsp_pkg::*;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_SOI2  = 3'd1;
    localparam logic [2:0] PH_MARK  = 3'd2;
    localparam logic [2:0] PH_CODE  = 3'd3;
    localparam logic [2:0] PH_LENHI = 3'd4;
    localparam logic [2:0] PH_LENLO = 3'd5;
    localparam logic [2:0] PH_BODY  = 3'd6;

    localparam logic [7:0] MK_FF   = 8'hFF;
    localparam logic [7:0] MK_SOI  = 8'hD8;
    localparam logic [7:0] MK_SOF0 = 8'hC0;
    localparam logic [7:0] MK_SOS  = 8'hDA;
    localparam logic [7:0] SAMP_11 = 8'h11;
    localparam logic [7:0] SAMP_21 = 8'h21;
    localparam logic [7:0] SAMP_22 = 8'h22;

    localparam logic [4:0] POS_FIRST = 5'd3;
    localparam logic [4:0] POS_MAX   = 5'd31;

    // Expected bytes of the three-component table, by segment position.
    function automatic logic [7:0] want3(input logic [4:0] pos);
        logic [7:0] v;
        begin
            unique case (pos)
                5'd9:    v = 8'd1;
                5'd12:   v = 8'd2;
                5'd13:   v = SAMP_11;
                5'd14:   v = 8'd1;
                5'd15:   v = 8'd3;
                5'd16:   v = SAMP_11;
                5'd17:   v = 8'd1;
                default: v = 8'd0;
            endcase
            return v;
        end
    endfunction

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] offset_reg, offset_next;
    logic [15:0] remain_reg, remain_next;
    logic [7:0]  marker_reg, marker_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [4:0]  pos_reg, pos_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [7:0]  count_reg, count_next;
    logic        match_reg, match_next;
    logic [7:0]  luma_reg, luma_next;
    logic [1:0]  format_reg, format_next;

    logic [15:0] len_full;
    logic [15:0] len_eff;
    logic [15:0] remain_dec;
    logic        match_upd;
    logic        sof_err;
    logic [2:0]  sof_status;

    assign len_full   = {len_hi_reg, data_byte};
    assign len_eff    = (len_full < 16'd2) ? 16'd2 : len_full;
    assign remain_dec = remain_reg - 16'd1;
    assign match_upd  = match_reg & (data_byte == want3(pos_reg));

    always_comb
    begin
        phase_next  = phase_reg;
        offset_next = offset_reg;
        remain_next = remain_reg;
        marker_next = marker_reg;
        len_hi_next = len_hi_reg;
        pos_next    = pos_reg;
        width_next  = width_reg;
        height_next = height_reg;
        count_next  = count_reg;
        match_next  = match_reg;
        luma_next   = luma_reg;
        format_next = format_reg;
        sof_err     = 1'b0;
        sof_status  = ST_OK;
        result      = '0;
        result.pixel_format = FMT_NONE;

        if (start_flag)
        begin
            offset_next = 16'd1;
            remain_next = '0;
            marker_next = '0;
            len_hi_next = '0;
            pos_next    = '0;
            width_next  = '0;
            height_next = '0;
            count_next  = '0;
            match_next  = 1'b1;
            luma_next   = '0;
            format_next = FMT_NONE;
            if (data_byte != MK_FF)
            begin
                phase_next    = PH_IDLE;
                result.emit   = 1'b1;
                result.status = ST_NO_SOI;
            end
            else
            begin
                phase_next = PH_SOI2;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            offset_next = offset_reg + 16'd1;
            unique case (phase_reg)
                PH_SOI2:
                begin
                    if (data_byte != MK_SOI)
                    begin
                        phase_next    = PH_IDLE;
                        result.emit   = 1'b1;
                        result.status = ST_NO_SOI;
                    end
                    else
                    begin
                        phase_next = PH_MARK;
                    end
                end
                PH_MARK:
                begin
                    if (data_byte != MK_FF)
                    begin
                        phase_next    = PH_IDLE;
                        result.emit   = 1'b1;
                        result.status = ST_NO_FF;
                    end
                    else
                    begin
                        phase_next = PH_CODE;
                    end
                end
                PH_CODE:
                begin
                    marker_next = data_byte;
                    phase_next  = PH_LENHI;
                end
                PH_LENHI:
                begin
                    len_hi_next = data_byte;
                    phase_next  = PH_LENLO;
                end
                PH_LENLO:
                begin
                    if (marker_reg == MK_SOS)
                    begin
                        phase_next           = PH_IDLE;
                        result.emit          = 1'b1;
                        result.status        = ST_OK;
                        result.image_width   = width_reg;
                        result.image_height  = height_reg;
                        result.pixel_format  = format_reg;
                        result.header_length = offset_reg + len_eff - 16'd1;
                    end
                    else
                    begin
                        remain_next = len_eff - 16'd2;
                        pos_next    = POS_FIRST;
                        phase_next  = (len_eff != 16'd2) ? PH_BODY : PH_MARK;
                    end
                end
                PH_BODY:
                begin
                    if (marker_reg == MK_SOF0)
                    begin
                        unique case (pos_reg)
                            5'd3:
                            begin
                                if (data_byte != 8'd8)
                                begin
                                    sof_err    = 1'b1;
                                    sof_status = ST_BAD_SOF;
                                end
                            end
                            5'd4: height_next = {data_byte, height_reg[7:0]};
                            5'd5: height_next = {height_reg[15:8], data_byte};
                            5'd6: width_next  = {data_byte, width_reg[7:0]};
                            5'd7: width_next  = {width_reg[15:8], data_byte};
                            5'd8:
                            begin
                                count_next = data_byte;
                                match_next = 1'b1;
                                if (data_byte != 8'd1 && data_byte != 8'd3)
                                begin
                                    sof_err    = 1'b1;
                                    sof_status = ST_BAD_COUNT;
                                end
                            end
                            default:
                            begin
                                if (pos_reg >= 5'd9 && pos_reg <= 5'd17)
                                begin
                                    if (count_reg == 8'd1)
                                    begin
                                        if (pos_reg == 5'd9 && data_byte != 8'd1)
                                        begin
                                            match_next = 1'b0;
                                        end
                                        if (pos_reg == 5'd10 && data_byte != SAMP_11)
                                        begin
                                            match_next = 1'b0;
                                        end
                                        if (pos_reg == 5'd11)
                                        begin
                                            if (data_byte != 8'd0 || !match_reg)
                                            begin
                                                sof_err    = 1'b1;
                                                sof_status = ST_BAD_SOF;
                                            end
                                            else
                                            begin
                                                format_next = FMT_GRAY;
                                            end
                                        end
                                    end
                                    else if (pos_reg == 5'd10)
                                    begin
                                        luma_next = data_byte;
                                    end
                                    else
                                    begin
                                        match_next = match_upd;
                                        if (pos_reg == 5'd17 && match_upd)
                                        begin
                                            priority if (luma_reg == SAMP_21)
                                            begin
                                                format_next = FMT_NV16;
                                            end
                                            else if (luma_reg == SAMP_22)
                                            begin
                                                format_next = FMT_NV12;
                                            end
                                            else
                                            begin
                                                sof_err    = 1'b1;
                                                sof_status = ST_BAD_SOF;
                                            end
                                        end
                                    end
                                end
                            end
                        endcase
                    end
                    if (sof_err)
                    begin
                        phase_next    = PH_IDLE;
                        result.emit   = 1'b1;
                        result.status = sof_status;
                    end
                    else
                    begin
                        remain_next = remain_dec;
                        pos_next    = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 5'd1;
                        if (remain_dec == 16'd0)
                        begin
                            phase_next = PH_MARK;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        if (!step_en)
        begin
            result.emit = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            offset_reg <= '0;
            remain_reg <= '0;
            marker_reg <= '0;
            len_hi_reg <= '0;
            pos_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            count_reg  <= '0;
            match_reg  <= 1'b1;
            luma_reg   <= '0;
            format_reg <= FMT_NONE;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            remain_reg <= remain_next;
            marker_reg <= marker_next;
            len_hi_reg <= len_hi_next;
            pos_reg    <= pos_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            count_reg  <= count_next;
            match_reg  <= match_next;
            luma_reg   <= luma_next;
            format_reg <= format_next;
        end
    end

endmodule

`default_nettype wire

@@ tb/tb_jpeg_header_sof_parser.sv @@
module tb_jpeg_header_sof_parser;

    import jhsp_pkg::*;

    localparam logic [7:0] MK_PREFIX     = 8'hFF;
    localparam logic [7:0] MK_SOI        = 8'hD8;
    localparam logic [7:0] MK_SOF0       = 8'hC0;
    localparam logic [7:0] MK_SOS        = 8'hDA;
    localparam logic [7:0] MK_APP0       = 8'hE0;
    localparam logic [7:0] MK_F1         = 8'hF1;
    localparam logic [7:0] MK_F2         = 8'hF2;
    localparam logic [7:0] SOF_PRECISION = 8'd8;
    localparam logic [7:0] SAMP_H1V1     = 8'h11;
    localparam logic [7:0] SAMP_H2V1     = 8'h21;
    localparam logic [7:0] SAMP_H2V2     = 8'h22;
    localparam int         RANDOM_BYTES  = 1400;
    localparam result_t    NO_WORD       = '0;

    typedef enum logic [2:0] {
        HDR_IDLE,
        HDR_SOI2,
        HDR_MARK,
        HDR_CODE,
        HDR_LENHI,
        HDR_LENLO,
        HDR_BODY
    } hdr_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       pinned;
        result_t    word;
    } stim_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        start_flag = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [1:0]  pixel_format;
    logic [15:0] header_length;

    logic        in_pinned = 1'b0;
    result_t     in_pinned_word = '0;

    hdr_phase_t  hdr_phase;
    logic [15:0] hdr_offset;
    logic [15:0] hdr_remaining;
    logic [15:0] hdr_seg_len;
    logic [15:0] hdr_width;
    logic [15:0] hdr_height;
    logic [7:0]  hdr_marker;
    logic [7:0]  hdr_count;
    logic [7:0]  hdr_luma;
    logic        hdr_comps_ok;
    logic [1:0]  hdr_format;

    result_t     expected_results[$];
    stim_row_t   directed_rows[$];
    logic [7:0]  header_bytes[$];
    logic [7:0]  seg_body[$];
    int          mismatch_count = 0;
    int          burst_left = 0;
    int          ready_mode = 0;
    int          ready_hold = 0;

    jpeg_header_sof_parser DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_byte(data_byte),
        .start_flag(start_flag),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .image_width(image_width),
        .image_height(image_height),
        .pixel_format(pixel_format),
        .header_length(header_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void clear_header_state();
        hdr_phase     = HDR_IDLE;
        hdr_offset    = 16'd0;
        hdr_remaining = 16'd0;
        hdr_seg_len   = 16'd0;
        hdr_width     = 16'd0;
        hdr_height    = 16'd0;
        hdr_marker    = 8'd0;
        hdr_count     = 8'd0;
        hdr_comps_ok  = 1'b1;
        hdr_luma      = 8'd0;
        hdr_format    = FMT_NONE;
    endfunction

    function automatic result_t fixed_word(input logic [2:0] st, input logic [15:0] w,
                                           input logic [15:0] h, input logic [1:0] fmt,
                                           input logic [15:0] hl);
        return {1'b1, st, w, h, fmt, hl};
    endfunction

    function automatic result_t header_error(input logic [2:0] st);
        hdr_phase = HDR_IDLE;
        return fixed_word(st, 16'd0, 16'd0, FMT_NONE, 16'd0);
    endfunction

    function automatic logic [2:0] check_sof0_byte(input logic [15:0] pos, input logic [7:0] b);
        logic [7:0] want;
        case (pos)
            16'd3: return (b != SOF_PRECISION) ? ST_BAD_SOF : ST_OK;
            16'd4: hdr_height[15:8] = b;
            16'd5: hdr_height[7:0] = b;
            16'd6: hdr_width[15:8] = b;
            16'd7: hdr_width[7:0] = b;
            16'd8:
            begin
                hdr_count = b;
                hdr_comps_ok = 1'b1;
                return (b != 8'd1 && b != 8'd3) ? ST_BAD_COUNT : ST_OK;
            end
            default: ;
        endcase
        if (pos < 16'd9 || pos > 16'd17)
            return ST_OK;
        if (hdr_count == 8'd1)
        begin
            if (pos == 16'd9 && b != 8'h01)
                hdr_comps_ok = 1'b0;
            if (pos == 16'd10 && b != SAMP_H1V1)
                hdr_comps_ok = 1'b0;
            if (pos == 16'd11)
            begin
                if (b != 8'h00 || !hdr_comps_ok)
                    return ST_BAD_SOF;
                hdr_format = FMT_GRAY;
            end
            return ST_OK;
        end
        if (pos == 16'd10)
        begin
            hdr_luma = b;
            return ST_OK;
        end
        case (pos)
            16'd9, 16'd14, 16'd17: want = 8'h01;
            16'd12: want = 8'h02;
            16'd15: want = 8'h03;
            16'd13, 16'd16: want = SAMP_H1V1;
            default: want = 8'h00;
        endcase
        if (b != want)
            hdr_comps_ok = 1'b0;
        if (pos == 16'd17 && hdr_comps_ok)
        begin
            if (hdr_luma == SAMP_H2V1)
                hdr_format = FMT_NV16;
            else if (hdr_luma == SAMP_H2V2)
                hdr_format = FMT_NV12;
            else
                return ST_BAD_SOF;
        end
        return ST_OK;
    endfunction

    function automatic result_t predict_header_byte(input logic [7:0] b, input logic start);
        result_t     r;
        logic [15:0] off;
        logic [15:0] len;
        logic [15:0] pos;
        logic [2:0]  err;
        r = NO_WORD;
        if (start)
        begin
            clear_header_state();
            hdr_offset = 16'd1;
            if (b != MK_PREFIX)
                return header_error(ST_NO_SOI);
            hdr_phase = HDR_SOI2;
            return r;
        end
        if (hdr_phase == HDR_IDLE)
            return r;
        off = hdr_offset;
        hdr_offset = off + 16'd1;
        case (hdr_phase)
            HDR_SOI2:
            begin
                if (b != MK_SOI)
                    return header_error(ST_NO_SOI);
                hdr_phase = HDR_MARK;
            end
            HDR_MARK:
            begin
                if (b != MK_PREFIX)
                    return header_error(ST_NO_FF);
                hdr_phase = HDR_CODE;
            end
            HDR_CODE:
            begin
                hdr_marker = b;
                hdr_phase = HDR_LENHI;
            end
            HDR_LENHI:
            begin
                hdr_seg_len = {b, 8'h00};
                hdr_phase = HDR_LENLO;
            end
            HDR_LENLO:
            begin
                len = {hdr_seg_len[15:8], b};
                if (len < 16'd2)
                    len = 16'd2;
                hdr_seg_len = len;
                if (hdr_marker == MK_SOS)
                begin
                    hdr_phase = HDR_IDLE;
                    r = fixed_word(ST_OK, hdr_width, hdr_height, hdr_format,
                                   off + len - 16'd1);
                end
                else
                begin
                    hdr_remaining = len - 16'd2;
                    hdr_phase = (hdr_remaining != 16'd0) ? HDR_BODY : HDR_MARK;
                end
            end
            HDR_BODY:
            begin
                pos = 16'd3 + (hdr_seg_len - 16'd2 - hdr_remaining);
                if (hdr_marker == MK_SOF0)
                begin
                    err = check_sof0_byte(pos, b);
                    if (err != ST_OK)
                        return header_error(err);
                end
                hdr_remaining = hdr_remaining - 16'd1;
                if (hdr_remaining == 16'd0)
                    hdr_phase = HDR_MARK;
            end
            default: hdr_phase = HDR_IDLE;
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_monitor
        result_t want;
        result_t predicted;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("status: expected no word, got %0d", status);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, status);
                    check_field("image_width", want.image_width, image_width);
                    check_field("image_height", want.image_height, image_height);
                    check_field("pixel_format", want.pixel_format, pixel_format);
                    check_field("header_length", want.header_length, header_length);
                end
            end
            if (in_valid && in_ready)
            begin
                predicted = predict_header_byte(data_byte, start_flag);
                if (in_pinned)
                    predicted = in_pinned_word;
                if (predicted.emit)
                    expected_results.push_back(predicted);
            end
        end
    end

    always @(posedge clk)
    begin
        if (ready_hold == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_hold = $urandom_range(8, 64);
        end
        else
            ready_hold--;
        case (ready_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= ready_hold[1];
        endcase
    end

    function automatic logic [7:0] rand_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic logic [15:0] pick_dimension();
        logic [15:0] v;
        case ($urandom_range(0, 5))
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            2: v = 16'($urandom_range(1, 16));
            default: v = 16'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    function automatic void add_row(input logic [7:0] d, input logic s, input logic pin,
                                    input result_t w);
        directed_rows.push_back({d, s, pin, w});
    endfunction

    function automatic void build_sof0_body();
        logic [15:0] h;
        logic [15:0] w;
        logic [7:0]  luma;
        h = pick_dimension();
        w = pick_dimension();
        case ($urandom_range(0, 5))
            0, 1: luma = SAMP_H2V1;
            2, 3: luma = SAMP_H2V2;
            4: luma = SAMP_H1V1;
            default: luma = rand_byte();
        endcase
        seg_body.delete();
        seg_body.push_back(($urandom_range(0, 9) == 0) ? rand_byte() : SOF_PRECISION);
        seg_body.push_back(h[15:8]);
        seg_body.push_back(h[7:0]);
        seg_body.push_back(w[15:8]);
        seg_body.push_back(w[7:0]);
        if ($urandom_range(0, 2) != 0)
        begin
            seg_body.push_back(8'd3);
            seg_body.push_back(8'h01);
            seg_body.push_back(luma);
            seg_body.push_back(8'h00);
            seg_body.push_back(8'h02);
            seg_body.push_back(SAMP_H1V1);
            seg_body.push_back(8'h01);
            seg_body.push_back(8'h03);
            seg_body.push_back(SAMP_H1V1);
            seg_body.push_back(8'h01);
        end
        else
        begin
            seg_body.push_back(8'd1);
            seg_body.push_back(8'h01);
            seg_body.push_back(SAMP_H1V1);
            seg_body.push_back(8'h00);
        end
        if ($urandom_range(0, 9) == 0)
            seg_body[5] = rand_byte();
        if ($urandom_range(0, 4) == 0)
            seg_body[$urandom_range(6, seg_body.size() - 1)] = rand_byte();
    endfunction

    function automatic void append_segment(input logic [7:0] code, input logic [15:0] len_field);
        int body_len;
        header_bytes.push_back(MK_PREFIX);
        header_bytes.push_back(code);
        header_bytes.push_back(len_field[15:8]);
        header_bytes.push_back(len_field[7:0]);
        body_len = (len_field < 16'd2) ? 0 : len_field - 16'd2;
        for (int i = 0; i < body_len; i++)
            header_bytes.push_back((i < seg_body.size()) ? seg_body[i] : rand_byte());
    endfunction

    function automatic void build_header();
        int          segs;
        logic [15:0] len;
        logic [7:0]  code;
        header_bytes.delete();
        header_bytes.push_back(MK_PREFIX);
        header_bytes.push_back(MK_SOI);
        segs = $urandom_range(0, 3);
        for (int n = 0; n < segs; n++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                seg_body.delete();
                repeat ($urandom_range(0, 5)) seg_body.push_back(rand_byte());
                case ($urandom_range(0, 4))
                    0: code = MK_PREFIX;
                    1: code = MK_F1;
                    2: code = MK_F2;
                    3: code = MK_APP0;
                    default: code = rand_byte();
                endcase
                if (code == MK_SOS)
                    code = MK_APP0;
                len = 16'(seg_body.size() + 2);
                if ($urandom_range(0, 7) == 0)
                    len = 16'($urandom_range(0, 1));
                append_segment(code, len);
            end
            else
            begin
                build_sof0_body();
                len = 16'(seg_body.size() + 2);
                if ($urandom_range(0, 5) == 0)
                    len = 16'($urandom_range(0, seg_body.size() + 4));
                append_segment(MK_SOF0, len);
            end
        end
        case ($urandom_range(0, 7))
            0: len = 16'd0;
            1: len = 16'd1;
            2: len = 16'hFFFF;
            3: len = 16'($urandom_range(0, 65535));
            default: len = 16'($urandom_range(6, 14));
        endcase
        header_bytes.push_back(MK_PREFIX);
        header_bytes.push_back(MK_SOS);
        header_bytes.push_back(len[15:8]);
        header_bytes.push_back(len[7:0]);
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic s, input logic pin,
                             input result_t w);
        int gap;
        in_valid <= 1'b1;
        data_byte <= d;
        start_flag <= s;
        in_pinned <= pin;
        in_pinned_word <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 30);
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        int   kind;
        int   random_sent;
        int   cut;
        logic s;
        clear_header_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(8'h5A, 1'b0, 1'b1, NO_WORD);
        add_row(8'h00, 1'b1, 1'b1, fixed_word(ST_NO_SOI, 16'd0, 16'd0, FMT_NONE, 16'd0));
        add_row(MK_PREFIX, 1'b1, 1'b0, NO_WORD);
        add_row(MK_SOI, 1'b0, 1'b0, NO_WORD);
        add_row(8'h12, 1'b0, 1'b1, fixed_word(ST_NO_FF, 16'd0, 16'd0, FMT_NONE, 16'd0));
        add_row(MK_PREFIX, 1'b1, 1'b0, NO_WORD);
        add_row(MK_SOI, 1'b0, 1'b0, NO_WORD);
        add_row(MK_PREFIX, 1'b0, 1'b0, NO_WORD);
        add_row(MK_SOF0, 1'b0, 1'b0, NO_WORD);
        add_row(8'h00, 1'b0, 1'b0, NO_WORD);
        add_row(8'h0B, 1'b0, 1'b0, NO_WORD);
        add_row(SOF_PRECISION, 1'b0, 1'b0, NO_WORD);
        add_row(8'hFF, 1'b0, 1'b0, NO_WORD);
        add_row(8'hFF, 1'b0, 1'b0, NO_WORD);
        add_row(8'hFF, 1'b0, 1'b0, NO_WORD);
        add_row(8'hFF, 1'b0, 1'b0, NO_WORD);
        add_row(8'h01, 1'b0, 1'b0, NO_WORD);
        add_row(8'h01, 1'b0, 1'b0, NO_WORD);
        add_row(SAMP_H1V1, 1'b0, 1'b0, NO_WORD);
        add_row(8'h00, 1'b0, 1'b0, NO_WORD);
        add_row(MK_PREFIX, 1'b0, 1'b0, NO_WORD);
        add_row(MK_SOS, 1'b0, 1'b0, NO_WORD);
        add_row(8'h00, 1'b0, 1'b0, NO_WORD);
        add_row(8'h0C, 1'b0, 1'b1, fixed_word(ST_OK, 16'hFFFF, 16'hFFFF, FMT_GRAY, 16'd29));
        add_row(MK_PREFIX, 1'b0, 1'b1, NO_WORD);
        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].start,
                      directed_rows[i].pinned, directed_rows[i].word);

        random_sent = 0;
        while (random_sent < RANDOM_BYTES)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                header_bytes.delete();
                repeat ($urandom_range(1, 10)) header_bytes.push_back(rand_byte());
            end
            else
            begin
                build_header();
                if (kind == 1)
                begin
                    if ($urandom_range(0, 1) == 0)
                        header_bytes[$urandom_range(1, header_bytes.size() - 1)] = rand_byte();
                    else
                    begin
                        cut = $urandom_range(1, header_bytes.size() - 1);
                        while (header_bytes.size() > cut)
                            header_bytes.delete(header_bytes.size() - 1);
                    end
                end
            end
            for (int i = 0; i < header_bytes.size(); i++)
            begin
                if (i == 0)
                    s = (kind != 0) || ($urandom_range(0, 1) == 1);
                else
                    s = (kind == 0) && ($urandom_range(0, 7) == 0);
                send_byte(header_bytes[i], s, 1'b0, NO_WORD);
                random_sent++;
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_byte(rand_byte(), 1'b0, 1'b0, NO_WORD);
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
